// ----- design/pmu_pkg.sv -----
package pmu_pkg;

    localparam int PAGE_BYTES  = 4;
    localparam int PAGE_COUNT  = 64;
    localparam int FRAME_COUNT = 8;
    localparam int VIRT_BYTES  = PAGE_COUNT * PAGE_BYTES;

    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int CNT_W   = OFF_W + 1;
    localparam int SCAN_W  = PAGE_W + 1;
    localparam int PHYS_W  = FRAME_W + OFF_W;
    localparam int BACK_W  = PAGE_W + OFF_W;

    localparam int VA_W    = 16;
    localparam int PID_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int PROT_W  = 3;
    localparam int OWNER_W = 3;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 3;
    localparam int USE_W   = 16;
    localparam int STAMP_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [USE_W-1:0] USE_MAX = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_EXEC  = 3'd2,
        REQ_ATTR  = 3'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_OOB        = 3'd1,
        ST_PID        = 3'd2,
        ST_RD_DENIED  = 3'd3,
        ST_WR_DENIED  = 3'd4,
        ST_EX_DENIED  = 3'd5,
        ST_INVALID    = 3'd6
    } status_t;

    localparam logic [PADDR_W-1:0] REG_MODE = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PT_RD,
        S_PT_CHK,
        S_ATTR_WR,
        S_SCAN,
        S_WB_RD,
        S_WB_WR,
        S_EVICT,
        S_LD_RD,
        S_LD_WR,
        S_LD_FIN,
        S_ACCESS,
        S_DATA,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [USE_W-1:0]   uses;
        logic [STAMP_W-1:0] stamp;
        logic [PROT_W-1:0]  perm;
        logic [OWNER_W-1:0] owner;
    } pte_t;

    localparam int PTE_W = $bits(pte_t);

    typedef struct packed {
        logic accept;
        logic pt_rd;
        logic pt_cap;
        logic attr_wr;
        logic scan_clr;
        logic scan_step;
        logic scan_end;
        logic evict;
        logic cnt_clr;
        logic wb_rd;
        logic wb_wr;
        logic ld_wr;
        logic ld_fin;
        logic access;
        logic data_cap;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic oob;
        logic attr;
        logic resident;
        logic free_ok;
        logic scan_done;
        logic victim_dirty;
        logic copy_done;
        logic need_read;
        logic out_free;
    } sts_t;

endpackage

// ----- design/paged_memory_unit_lfu_lru_core.sv -----
// Paged memory unit: one read, write, execute or page-attribute load per item,
// one result per item, one item in flight at a time. A hit on a resident page
// checks the page table and then accesses the frame, reading the frame back
// only for a read that succeeds; an attribute load writes the page table entry
// and an out-of-bounds address goes straight to the result. A fault with a free
// frame adds a byte-by-byte page copy from backing store. A fault with every
// frame busy adds instead a victim scan over the 64-entry page table through its
// single read port, an eviction step and the page load; a dirty victim is first
// written back byte by byte. replacement_mode (APB offset 0) picks least
// frequently used (0) or least recently used (1) victims.
module paged_memory_unit_lfu_lru_core
    import pmu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [VA_W-1:0]     s_virt_addr,
    input  logic [PID_W-1:0]    s_pid,
    input  logic [BYTE_W-1:0]   s_write_value,
    input  logic [PROT_W-1:0]   s_attr_prot,
    input  logic [OWNER_W-1:0]  s_attr_owner,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [BYTE_W-1:0]   m_read_data,
    output logic [PHYS_W-1:0]   m_phys_addr,
    output logic                m_page_fault,
    output logic                m_evicted,
    output logic [PAGE_W-1:0]   m_victim_page,
    output logic                m_wrote_back
);

    logic mode_reg;
    ctl_t ctl;
    sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MODE) ? PDATA_W'(mode_reg) : '0;

    pmu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    pmu_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .sts           (sts),
        .mode          (mode_reg),
        .s_req_type    (s_req_type),
        .s_virt_addr   (s_virt_addr),
        .s_pid         (s_pid),
        .s_write_value (s_write_value),
        .s_attr_prot   (s_attr_prot),
        .s_attr_owner  (s_attr_owner),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_data   (m_read_data),
        .m_phys_addr   (m_phys_addr),
        .m_page_fault  (m_page_fault),
        .m_evicted     (m_evicted),
        .m_victim_page (m_victim_page),
        .m_wrote_back  (m_wrote_back)
    );

`ifndef SYNTHESIS
    a_wb_needs_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wrote_back |-> m_evicted)
        else $error("write-back without eviction");

    a_evict_needs_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> m_page_fault)
        else $error("eviction without page fault");

    a_oob_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OOB |-> m_phys_addr == '0 && !m_page_fault)
        else $error("out-of-bounds item touched paging");

    a_read_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_read_data == '0)
        else $error("read data on failed item");
`endif

endmodule

// ----- design/pmu_ram.sv -----
module pmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/pmu_ctrl.sv -----
module pmu_ctrl
    import pmu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_PT_RD;
            S_PT_RD:   state_next = sts.oob ? S_FINISH : S_PT_CHK;
            S_PT_CHK: begin
                priority if (sts.attr)     state_next = S_ATTR_WR;
                else if (sts.resident)     state_next = S_ACCESS;
                else if (sts.free_ok)      state_next = S_LD_RD;
                else                       state_next = S_SCAN;
            end
            S_ATTR_WR: state_next = S_FINISH;
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = sts.victim_dirty ? S_WB_RD : S_EVICT;
                end
            end
            S_WB_RD:   state_next = sts.copy_done ? S_EVICT : S_WB_WR;
            S_WB_WR:   state_next = S_WB_RD;
            S_EVICT:   state_next = S_LD_RD;
            S_LD_RD:   state_next = sts.copy_done ? S_LD_FIN : S_LD_WR;
            S_LD_WR:   state_next = S_LD_RD;
            S_LD_FIN:  state_next = S_ACCESS;
            S_ACCESS:  state_next = sts.need_read ? S_DATA : S_FINISH;
            S_DATA:    state_next = S_FINISH;
            S_FINISH:  if (sts.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                ctl.accept = s_valid;
            end
            S_PT_RD:   ctl.pt_rd = 1'b1;
            S_PT_CHK: begin
                ctl.pt_cap   = 1'b1;
                ctl.scan_clr = 1'b1;
                ctl.cnt_clr  = 1'b1;
            end
            S_ATTR_WR: ctl.attr_wr = 1'b1;
            S_SCAN: begin
                ctl.scan_step = 1'b1;
                ctl.scan_end  = sts.scan_done;
                ctl.cnt_clr   = 1'b1;
            end
            S_WB_RD:   ctl.wb_rd = 1'b1;
            S_WB_WR:   ctl.wb_wr = 1'b1;
            S_EVICT: begin
                ctl.evict   = 1'b1;
                ctl.cnt_clr = 1'b1;
            end
            S_LD_WR:   ctl.ld_wr = 1'b1;
            S_LD_FIN:  ctl.ld_fin = 1'b1;
            S_ACCESS:  ctl.access = 1'b1;
            S_DATA:    ctl.data_cap = 1'b1;
            S_FINISH:  ctl.finish = sts.out_free;
            default:   ctl = '0;
        endcase
    end

endmodule

// ----- design/pmu_datapath.sv -----
module pmu_datapath
    import pmu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctl_t                ctl,
    output sts_t                sts,
    input  logic                mode,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [VA_W-1:0]     s_virt_addr,
    input  logic [PID_W-1:0]    s_pid,
    input  logic [BYTE_W-1:0]   s_write_value,
    input  logic [PROT_W-1:0]   s_attr_prot,
    input  logic [OWNER_W-1:0]  s_attr_owner,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [BYTE_W-1:0]   m_read_data,
    output logic [PHYS_W-1:0]   m_phys_addr,
    output logic                m_page_fault,
    output logic                m_evicted,
    output logic [PAGE_W-1:0]   m_victim_page,
    output logic                m_wrote_back
);

    logic [REQ_W-1:0]    req_reg;
    logic [VA_W-1:0]     va_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [BYTE_W-1:0]   wval_reg;
    logic [PROT_W-1:0]   prot_reg;
    logic [OWNER_W-1:0]  own_reg;

    logic [PAGE_COUNT-1:0]  resident_reg;
    logic [PAGE_COUNT-1:0]  dirty_reg;
    logic [PAGE_COUNT-1:0]  pt_vld_reg;
    logic [VIRT_BYTES-1:0]  bk_vld_reg;
    logic [FRAME_COUNT-1:0] busy_reg;
    logic [STAMP_W-1:0]     clock_reg;
    logic                   pt_rvld_reg;
    logic                   bk_rvld_reg;

    pte_t                pte_reg;
    logic [FRAME_W-1:0]  vf_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [SCAN_W-1:0]   scan_idx_reg;
    logic                pend_reg;
    logic [PAGE_W-1:0]   pend_pg_reg;
    logic                found_reg;
    logic [STAMP_W-1:0]  best_key_reg;
    logic [PAGE_W-1:0]   best_pg_reg;
    pte_t                best_pte_reg;

    logic [STAT_W-1:0]   status_reg;
    logic [BYTE_W-1:0]   rdata_reg;
    logic [PHYS_W-1:0]   phys_reg;
    logic                fault_reg;
    logic                evict_reg;
    logic [PAGE_W-1:0]   victim_reg;
    logic                wb_reg;
    logic                m_valid_reg;

    logic [PAGE_W-1:0]   page;
    logic [OFF_W-1:0]    off;
    logic [OFF_W-1:0]    boff;

    logic                pt_we;
    logic [PAGE_W-1:0]   pt_waddr;
    pte_t                pt_wdata;
    logic [PAGE_W-1:0]   pt_raddr;
    logic [PTE_W-1:0]    pt_rraw;
    pte_t                pt_rd;

    logic                fr_we;
    logic [PHYS_W-1:0]   fr_waddr;
    logic [BYTE_W-1:0]   fr_wdata;
    logic [PHYS_W-1:0]   fr_raddr;
    logic [BYTE_W-1:0]   fr_rdata;

    logic                bk_we;
    logic [BACK_W-1:0]   bk_waddr;
    logic [BACK_W-1:0]   bk_raddr;
    logic [BYTE_W-1:0]   bk_rdata;
    logic [BYTE_W-1:0]   bk_byte;

    logic                free_ok;
    logic [FRAME_W-1:0]  free_idx;
    logic [STAMP_W-1:0]  scan_key;
    logic                scan_take;

    logic [PHYS_W-1:0]   phys;
    logic                owner_ok;
    logic                perm_ok;
    logic [USE_W-1:0]    uses_inc;
    logic [STAT_W-1:0]   acc_status;
    pte_t                acc_pte;

    assign page = va_reg[OFF_W+PAGE_W-1:OFF_W];
    assign off  = va_reg[OFF_W-1:0];
    assign boff = cnt_reg[OFF_W-1:0];

    assign pt_rd   = pt_rvld_reg ? pte_t'(pt_rraw) : '0;
    assign bk_byte = bk_rvld_reg ? bk_rdata : '0;

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
            if (!busy_reg[f]) begin
                free_ok  = 1'b1;
                free_idx = FRAME_W'(f);
            end
        end
    end

    assign scan_key  = mode ? pt_rd.stamp : STAMP_W'(pt_rd.uses);
    assign scan_take = pend_reg && resident_reg[pend_pg_reg]
                       && (!found_reg || scan_key < best_key_reg);

    assign phys     = {pte_reg.frame, off};
    assign owner_ok = (pid_reg == PID_W'(pte_reg.owner));
    assign perm_ok  = pte_reg.perm[req_reg[1:0]];
    assign uses_inc = (pte_reg.uses == USE_MAX) ? pte_reg.uses : pte_reg.uses + 1'b1;

    always_comb begin
        acc_pte       = pte_reg;
        acc_pte.stamp = clock_reg;
        acc_status    = ST_OK;
        priority if (!owner_ok) begin
            acc_status = ST_PID;
        end else if (req_reg > REQ_EXEC) begin
            acc_status = ST_INVALID;
        end else begin
            acc_pte.uses = uses_inc;
            if (!perm_ok) begin
                unique case (req_reg)
                    REQ_READ:  acc_status = ST_RD_DENIED;
                    REQ_WRITE: acc_status = ST_WR_DENIED;
                    default:   acc_status = ST_EX_DENIED;
                endcase
            end
        end
    end

    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = page;
        pt_wdata = acc_pte;
        if (ctl.attr_wr) begin
            pt_we          = 1'b1;
            pt_wdata       = pte_reg;
            pt_wdata.perm  = prot_reg;
            pt_wdata.owner = own_reg;
        end else if (ctl.evict && found_reg) begin
            pt_we         = 1'b1;
            pt_waddr      = best_pg_reg;
            pt_wdata      = best_pte_reg;
            pt_wdata.uses = '0;
        end else if (ctl.access) begin
            pt_we = 1'b1;
        end
    end

    assign pt_raddr = ctl.pt_rd ? page : scan_idx_reg[PAGE_W-1:0];

    assign fr_raddr = ctl.wb_rd ? {vf_reg, boff} : phys;
    assign fr_we    = ctl.ld_wr || (ctl.access && acc_status == ST_OK && req_reg == REQ_WRITE);
    assign fr_waddr = ctl.ld_wr ? {vf_reg, boff} : phys;
    assign fr_wdata = ctl.ld_wr ? bk_byte : wval_reg;

    assign bk_raddr = {page, boff};
    assign bk_we    = ctl.wb_wr;
    assign bk_waddr = {best_pg_reg, boff};

    pmu_ram #(.WIDTH(PTE_W), .DEPTH(PAGE_COUNT)) u_pt_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rraw)
    );

    pmu_ram #(.WIDTH(BYTE_W), .DEPTH(FRAME_COUNT * PAGE_BYTES)) u_frame_ram (
        .aclk  (aclk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    pmu_ram #(.WIDTH(BYTE_W), .DEPTH(VIRT_BYTES)) u_back_ram (
        .aclk  (aclk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (fr_rdata),
        .raddr (bk_raddr),
        .rdata (bk_rdata)
    );

    always_ff @(posedge aclk) begin
        pt_rvld_reg <= pt_vld_reg[pt_raddr];
        bk_rvld_reg <= bk_vld_reg[bk_raddr];
        if (ctl.accept) begin
            req_reg  <= s_req_type;
            va_reg   <= s_virt_addr;
            pid_reg  <= s_pid;
            wval_reg <= s_write_value;
            prot_reg <= s_attr_prot;
            own_reg  <= s_attr_owner;
        end
        if (ctl.pt_cap) begin
            pte_reg <= pt_rd;
            vf_reg  <= free_idx;
        end
        if (ctl.ld_fin) begin
            pte_reg.frame <= vf_reg;
            pte_reg.uses  <= '0;
        end
        if (ctl.cnt_clr) begin
            cnt_reg <= '0;
        end else if (ctl.wb_wr || ctl.ld_wr) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (ctl.scan_clr) begin
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end else if (ctl.scan_step) begin
            pend_reg    <= (scan_idx_reg != SCAN_W'(PAGE_COUNT));
            pend_pg_reg <= scan_idx_reg[PAGE_W-1:0];
            if (scan_idx_reg != SCAN_W'(PAGE_COUNT)) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (scan_take) begin
            best_key_reg <= scan_key;
            best_pg_reg  <= pend_pg_reg;
            best_pte_reg <= pt_rd;
        end
        if (ctl.scan_end && found_reg) begin
            vf_reg <= best_pte_reg.frame;
        end else if (ctl.scan_end) begin
            vf_reg <= '0;
        end
        if (ctl.data_cap) begin
            rdata_reg <= fr_rdata;
        end
        if (ctl.access) begin
            phys_reg   <= phys;
            status_reg <= acc_status;
        end
        if (ctl.pt_rd && sts.oob) begin
            status_reg <= ST_OOB;
        end
        if (ctl.accept) begin
            status_reg <= ST_OK;
            rdata_reg  <= '0;
            phys_reg   <= '0;
            victim_reg <= '0;
        end
        if (ctl.scan_end && found_reg) begin
            victim_reg <= best_pg_reg;
        end
        if (ctl.finish) begin
            m_status      <= status_reg;
            m_read_data   <= rdata_reg;
            m_phys_addr   <= phys_reg;
            m_page_fault  <= fault_reg;
            m_evicted     <= evict_reg;
            m_victim_page <= victim_reg;
            m_wrote_back  <= wb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resident_reg <= '0;
            dirty_reg    <= '0;
            pt_vld_reg   <= '0;
            bk_vld_reg   <= '0;
            busy_reg     <= '0;
            clock_reg    <= '0;
            found_reg    <= 1'b0;
            fault_reg    <= 1'b0;
            evict_reg    <= 1'b0;
            wb_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (ctl.accept) begin
                fault_reg <= 1'b0;
                evict_reg <= 1'b0;
                wb_reg    <= 1'b0;
            end
            if (ctl.scan_clr) begin
                found_reg <= 1'b0;
            end else if (scan_take) begin
                found_reg <= 1'b1;
            end
            if (ctl.attr_wr) begin
                pt_vld_reg[page] <= 1'b1;
            end
            if (ctl.scan_end && found_reg) begin
                evict_reg <= 1'b1;
            end
            if (ctl.wb_wr) begin
                bk_vld_reg[bk_waddr] <= 1'b1;
                wb_reg               <= 1'b1;
            end
            if (ctl.evict && found_reg) begin
                resident_reg[best_pg_reg] <= 1'b0;
                dirty_reg[best_pg_reg]    <= 1'b0;
            end
            if (ctl.ld_fin) begin
                resident_reg[page] <= 1'b1;
                dirty_reg[page]    <= 1'b0;
                busy_reg[vf_reg]   <= 1'b1;
                fault_reg          <= 1'b1;
            end
            if (ctl.access) begin
                pt_vld_reg[page] <= 1'b1;
                clock_reg        <= clock_reg + 1'b1;
                if (acc_status == ST_OK && req_reg == REQ_WRITE) begin
                    dirty_reg[page] <= 1'b1;
                end
            end
            if (ctl.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    assign sts.oob          = (32'(va_reg) >= VIRT_BYTES);
    assign sts.attr         = (req_reg == REQ_ATTR);
    assign sts.resident     = resident_reg[page];
    assign sts.free_ok      = free_ok;
    assign sts.scan_done    = (scan_idx_reg == SCAN_W'(PAGE_COUNT)) && !pend_reg;
    assign sts.victim_dirty = found_reg && dirty_reg[best_pg_reg];
    assign sts.copy_done    = (cnt_reg == CNT_W'(PAGE_BYTES));
    assign sts.need_read    = (acc_status == ST_OK) && (req_reg == REQ_READ);
    assign sts.out_free     = !m_valid_reg || m_ready;

endmodule

// ----- verif/pmu_translation_checker.sv -----
module pmu_translation_checker
    import pmu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [VA_W-1:0]     s_virt_addr,
    input  logic [PID_W-1:0]    s_pid,
    input  logic [BYTE_W-1:0]   s_write_value,
    input  logic [PROT_W-1:0]   s_attr_prot,
    input  logic [OWNER_W-1:0]  s_attr_owner,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STAT_W-1:0]   m_status,
    input  logic [BYTE_W-1:0]   m_read_data,
    input  logic [PHYS_W-1:0]   m_phys_addr,
    input  logic                m_page_fault,
    input  logic                m_evicted,
    input  logic [PAGE_W-1:0]   m_victim_page,
    input  logic                m_wrote_back,
    output int                  fail_count,
    output int                  pending,
    output int                  result_count,
    output int                  fault_count,
    output int                  evict_count
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] read_data;
        logic [PHYS_W-1:0] phys_addr;
        logic              page_fault;
        logic              evicted;
        logic [PAGE_W-1:0] victim_page;
        logic              wrote_back;
    } xlate_result_t;

    xlate_result_t expected_results[$];

    logic               lru_mode;
    logic               resident[PAGE_COUNT];
    logic               dirty[PAGE_COUNT];
    logic [FRAME_W-1:0] frame_of[PAGE_COUNT];
    logic [USE_W-1:0]   uses[PAGE_COUNT];
    logic [STAMP_W-1:0] stamp[PAGE_COUNT];
    logic [PROT_W-1:0]  perm[PAGE_COUNT];
    logic [OWNER_W-1:0] owner[PAGE_COUNT];
    logic               busy[FRAME_COUNT];
    logic [BYTE_W-1:0]  frame_mem[FRAME_COUNT*PAGE_BYTES];
    logic [BYTE_W-1:0]  backing[VIRT_BYTES];
    logic [STAMP_W-1:0] access_clock;

    assign pending = expected_results.size();

    task automatic bring_in(int pg, int fr);
        for (int b = 0; b < PAGE_BYTES; b++)
            frame_mem[fr*PAGE_BYTES+b] = backing[pg*PAGE_BYTES+b];
        frame_of[pg] = FRAME_W'(fr);
        resident[pg] = 1'b1;
        dirty[pg] = 1'b0;
        uses[pg] = '0;
        busy[fr] = 1'b1;
    endtask

    task automatic translate_access(input logic [REQ_W-1:0] req, input logic [VA_W-1:0] va,
                                    input logic [PID_W-1:0] pid, input logic [BYTE_W-1:0] wval,
                                    input logic [PROT_W-1:0] aprot,
                                    input logic [OWNER_W-1:0] aowner,
                                    output xlate_result_t r);
        int pg, off, fr, vp, vf, pa;
        logic [STAMP_W-1:0] key, best_key;
        r = '0;
        if (va >= VA_W'(VIRT_BYTES)) begin
            r.status = ST_OOB;
            return;
        end
        pg = va / PAGE_BYTES;
        off = va % PAGE_BYTES;
        if (req == REQ_ATTR) begin
            perm[pg] = aprot;
            owner[pg] = aowner;
            return;
        end
        if (!resident[pg]) begin
            r.page_fault = 1'b1;
            fr = -1;
            for (int f = 0; f < FRAME_COUNT; f++)
                if (fr < 0 && !busy[f]) fr = f;
            if (fr >= 0) begin
                bring_in(pg, fr);
            end else begin
                vp = -1;
                best_key = '1;
                for (int p = 0; p < PAGE_COUNT; p++) begin
                    if (!resident[p]) continue;
                    key = lru_mode ? stamp[p] : STAMP_W'(uses[p]);
                    if (vp < 0 || key < best_key) begin
                        vp = p;
                        best_key = key;
                    end
                end
                vf = frame_of[vp];
                r.evicted = 1'b1;
                r.victim_page = PAGE_W'(vp);
                if (dirty[vp]) begin
                    for (int b = 0; b < PAGE_BYTES; b++)
                        backing[vp*PAGE_BYTES+b] = frame_mem[vf*PAGE_BYTES+b];
                    r.wrote_back = 1'b1;
                end
                resident[vp] = 1'b0;
                dirty[vp] = 1'b0;
                uses[vp] = '0;
                bring_in(pg, vf);
            end
        end
        pa = frame_of[pg] * PAGE_BYTES + off;
        r.phys_addr = PHYS_W'(pa);
        stamp[pg] = access_clock;
        access_clock = access_clock + 1;
        if (pid != PID_W'(owner[pg])) begin
            r.status = ST_PID;
            return;
        end
        if (req > REQ_EXEC) begin
            r.status = ST_INVALID;
            return;
        end
        if (uses[pg] != USE_MAX) uses[pg] = uses[pg] + 1;
        if (!perm[pg][req]) begin
            r.status = STAT_W'(ST_RD_DENIED + req);
            return;
        end
        if (req == REQ_READ) begin
            r.read_data = frame_mem[pa];
        end else if (req == REQ_WRITE) begin
            frame_mem[pa] = wval;
            dirty[pg] = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        xlate_result_t exp_r, got_r;
        if (!aresetn) begin
            lru_mode = 1'b0;
            for (int p = 0; p < PAGE_COUNT; p++) begin
                resident[p] = 0; dirty[p] = 0; frame_of[p] = '0; uses[p] = '0;
                stamp[p] = '0; perm[p] = '0; owner[p] = '0;
            end
            for (int f = 0; f < FRAME_COUNT; f++) busy[f] = 0;
            for (int i = 0; i < FRAME_COUNT*PAGE_BYTES; i++) frame_mem[i] = '0;
            for (int i = 0; i < VIRT_BYTES; i++) backing[i] = '0;
            access_clock = '0;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
            fault_count = 0;
            evict_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_MODE)
                lru_mode = pwdata[0];
            if (s_valid && s_ready) begin
                translate_access(s_req_type, s_virt_addr, s_pid, s_write_value,
                                 s_attr_prot, s_attr_owner, exp_r);
                expected_results.push_back(exp_r);
            end
            if (m_valid && m_ready) begin
                got_r = '{m_status, m_read_data, m_phys_addr, m_page_fault, m_evicted,
                          m_victim_page, m_wrote_back};
                result_count++;
                if (m_page_fault) fault_count++;
                if (m_evicted) evict_count++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: status=%0d", m_status);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r != exp_r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result %0d mismatch: exp st=%0d rd=%h pa=%0d pf=%b ev=%b ",
                                      "vp=%0d wb=%b, got st=%0d rd=%h pa=%0d pf=%b ev=%b ",
                                      "vp=%0d wb=%b"}, result_count,
                                     exp_r.status, exp_r.read_data, exp_r.phys_addr,
                                     exp_r.page_fault, exp_r.evicted, exp_r.victim_page,
                                     exp_r.wrote_back, got_r.status, got_r.read_data,
                                     got_r.phys_addr, got_r.page_fault, got_r.evicted,
                                     got_r.victim_page, got_r.wrote_back);
                    end
                end
            end
        end
    end

endmodule

// ----- verif/paged_memory_unit_lfu_lru_core_tb.sv -----
module paged_memory_unit_lfu_lru_core_tb;
    import pmu_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type = '0;
    logic [VA_W-1:0]     s_virt_addr = '0;
    logic [PID_W-1:0]    s_pid = '0;
    logic [BYTE_W-1:0]   s_write_value = '0;
    logic [PROT_W-1:0]   s_attr_prot = '0;
    logic [OWNER_W-1:0]  s_attr_owner = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [BYTE_W-1:0]   m_read_data;
    logic [PHYS_W-1:0]   m_phys_addr;
    logic                m_page_fault, m_evicted, m_wrote_back;
    logic [PAGE_W-1:0]   m_victim_page;

    int fail_count, pending, result_count, fault_count, evict_count;
    logic idle_on = 1'b1;
    int sink_hold = 0;
    int sent = 0;
    logic [OWNER_W-1:0] owner_shadow[PAGE_COUNT];

    always #6 aclk = ~aclk;

    paged_memory_unit_lfu_lru_core dut (.*);

    pmu_translation_checker checker_i (.*);

    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_item(logic [REQ_W-1:0] req, logic [VA_W-1:0] va, logic [PID_W-1:0] pid,
                             logic [BYTE_W-1:0] wv, logic [PROT_W-1:0] prot,
                             logic [OWNER_W-1:0] own);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req; s_virt_addr <= va; s_pid <= pid;
        s_write_value <= wv; s_attr_prot <= prot; s_attr_owner <= own;
        if (req == REQ_ATTR && va < VA_W'(VIRT_BYTES)) owner_shadow[va/PAGE_BYTES] = own;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic random_item();
        int pg, r;
        logic [VA_W-1:0] va;
        logic [PID_W-1:0] pid;
        logic [REQ_W-1:0] req;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            va = VA_W'($urandom_range(VIRT_BYTES, 65535));
            send_item(REQ_W'($urandom), va, PID_W'($urandom), BYTE_W'($urandom),
                      PROT_W'($urandom), OWNER_W'($urandom));
            return;
        end
        pg = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 11) : $urandom_range(0, 63);
        va = VA_W'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES-1));
        if (r < 20) begin
            send_item(REQ_ATTR, va, PID_W'($urandom), BYTE_W'($urandom),
                      PROT_W'($urandom), OWNER_W'($urandom));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 85) pid = PID_W'(owner_shadow[pg]);
        else if (r < 95) pid = PID_W'($urandom_range(0, 7));
        else pid = PID_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) req = REQ_READ;
        else if (r < 75) req = REQ_WRITE;
        else if (r < 92) req = REQ_EXEC;
        else req = REQ_W'($urandom_range(4, 7));
        send_item(req, va, pid, BYTE_W'($urandom), PROT_W'($urandom), OWNER_W'($urandom));
    endtask

    initial begin
        for (int p = 0; p < PAGE_COUNT; p++) owner_shadow[p] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: bounds, every request kind, pid mismatch, fill and evict
        send_item(REQ_READ, VA_W'(VIRT_BYTES), 8'd0, 8'd0, 3'd0, 3'd0);
        send_item(REQ_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 3'd7, 3'd7);
        send_item(REQ_READ, 16'd0, 8'd0, 8'd0, 3'd0, 3'd0);
        send_item(REQ_ATTR, 16'd1, 8'd0, 8'd0, 3'd7, 3'd0);
        send_item(REQ_WRITE, 16'd3, 8'd0, 8'hFF, 3'd0, 3'd0);
        send_item(REQ_READ, 16'd3, 8'd0, 8'd0, 3'd0, 3'd0);
        send_item(REQ_EXEC, 16'd2, 8'd0, 8'd0, 3'd0, 3'd0);
        send_item(REQ_W'(7), 16'd0, 8'd0, 8'd0, 3'd0, 3'd0);
        send_item(REQ_READ, 16'd0, 8'd255, 8'd0, 3'd0, 3'd0);
        send_item(REQ_ATTR, 16'd255, 8'd0, 8'd0, 3'd0, 3'd7);
        send_item(REQ_WRITE, 16'd254, 8'd7, 8'hA5, 3'd0, 3'd0);
        send_item(REQ_EXEC, 16'd253, 8'd7, 8'd0, 3'd0, 3'd0);
        for (int p = 1; p <= 9; p++)
            send_item(REQ_READ, VA_W'(p * PAGE_BYTES), 8'd0, 8'd0, 3'd0, 3'd0);
        send_item(REQ_READ, 16'd3, 8'd0, 8'd0, 3'd0, 3'd0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            apb_write(REG_MODE, PDATA_W'(ph % 2));
            if (ph == 4) idle_on = 1'b0;
            repeat (ph == 4 ? 150 : 300) random_item();
            drain();
        end
        apb_write(REG_MODE, 32'd0);
        repeat (2) @(posedge aclk);

        $display("sent %0d items, checked %0d results (%0d faults, %0d evictions)",
                 sent, result_count, fault_count, evict_count);
        $display("replacement mode alternated between LFU and LRU with and without idling");
        if (fail_count == 0 && pending == 0) begin
            $display("paged_memory_unit_lfu_lru_core verification clean");
        end else begin
            $display("paged_memory_unit_lfu_lru_core verification failed");
        end
        $finish;
    end

    initial begin
        #(12 * 1500000);
        $display("timeout");
        $display("paged_memory_unit_lfu_lru_core verification failed");
        $finish;
    end

endmodule

// ----- paged_memory_unit_lfu_lru_core.f -----
design/pmu_pkg.sv
design/pmu_ram.sv
design/pmu_ctrl.sv
design/pmu_datapath.sv
design/paged_memory_unit_lfu_lru_core.sv
verif/pmu_translation_checker.sv
verif/paged_memory_unit_lfu_lru_core_tb.sv
